// ===== sv/shke_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shke_pkg: shared types, constants and functions of the key hash engine
// Mode codes, hash constants, the internal item record and the CRC step.
// ----------------------------------------------------------------------------
package shke_pkg;

  // widths
  localparam int HASH_W         = 32;
  localparam int POSITION_WIDTH = 32;
  localparam int BYTE_W         = 8;
  localparam int MODE_W         = 3;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  // queue geometry (front queue and result queue)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // register indexes
  localparam logic [CFG_ADDR_W-3:0] REG_HASH_MODE = '0;

  // hash mode codes
  localparam logic [MODE_W-1:0] MODE_LEN  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUM  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POS  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DJB2 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CRC  = 3'd4;

  // hash constants
  localparam logic [HASH_W-1:0] DJB2_START = 32'd5381;
  localparam logic [HASH_W-1:0] CRC_POLY   = 32'h82F6_3B78;
  localparam logic [HASH_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam int                DJB2_SHIFT = 5;

  // one queued work item
  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic              present;
    logic              last;
    logic [MODE_W-1:0] mode;
  } shke_item_t;

  // unused codes fold onto CRC
  function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
    eff_mode = (m <= MODE_CRC) ? m : MODE_CRC;
  endfunction

  // reflected CRC-32C, one byte, bit by bit
  function automatic logic [HASH_W-1:0] crc_byte(input logic [HASH_W-1:0] crc_in,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] c;
    c = crc_in ^ HASH_W'(b);
    for (int k = 0; k < BYTE_W; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
    end
    crc_byte = c;
  endfunction

endpackage : shke_pkg
`default_nettype wire

// ===== sv/selectable_key_hash_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// selectable_key_hash_engine: streaming key hash with selectable function
// Length, byte sum, position-weighted sum, DJB2 or CRC-32C over a byte key.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         push / full          in_key_byte, in_byte_present,
//                                            in_last_byte
//  result    out        empty / pop          out_hash_value
//  config    in/out     psel/penable/pready  paddr, pwdata, prdata (hash_mode)
//
//  One key byte per cycle while full is low; the last item of a key waits in
//  the item queue, and its hash is written to the result queue at the edge
//  where the back part takes that item; the result ports show the queue head.
//  The per-byte step (CRC bit loop or 32x32 weight multiply) is combinational.
//  Reset clears both queues and the accumulator; hash_mode resets to CRC-32C.
//  Front and back stall independently through a two-entry item queue.
// ----------------------------------------------------------------------------
module selectable_key_hash_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input channel
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [shke_pkg::BYTE_W-1:0]       in_key_byte,
  input  wire logic                              in_byte_present,
  input  wire logic                              in_last_byte,
  // result channel
  output logic                                   empty,
  input  wire logic                              pop,
  output logic [shke_pkg::HASH_W-1:0]            out_hash_value,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [shke_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [shke_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [shke_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready
);
  import shke_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              cfg_wr;
  logic              hit_mode;
  logic              q_valid;
  logic              q_pop;
  shke_item_t        q_item;

  // configuration register
  assign pready   = 1'b1;
  assign hit_mode = (paddr[CFG_ADDR_W-1:2] == REG_HASH_MODE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = hit_mode ? CFG_DATA_W'(mode_r) : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && hit_mode) begin
      mode_nxt = pwdata[MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_CRC;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  // accept and classify
  shke_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_key_byte     (in_key_byte),
    .in_byte_present (in_byte_present),
    .in_last_byte    (in_last_byte),
    .hash_mode       (mode_r),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // hash datapath and result queue
  shke_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value)
  );

endmodule : selectable_key_hash_engine
`default_nettype wire

// ===== sv/shke_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shke_front: input side of the key hash engine
// Accepts key items, drops idle items and queues the rest with the mode.
// ----------------------------------------------------------------------------
module shke_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [shke_pkg::BYTE_W-1:0]   in_key_byte,
  input  wire logic                          in_byte_present,
  input  wire logic                          in_last_byte,
  input  wire logic [shke_pkg::MODE_W-1:0]   hash_mode,
  output logic                               q_valid,
  output shke_pkg::shke_item_t               q_item,
  input  wire logic                          q_pop
);
  import shke_pkg::*;

  shke_item_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              accept;
  logic              wr_en;
  logic              rd_en;
  shke_item_t        item_in;

  // classify: idle items are taken but never queued
  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign accept  = push && !full;
  assign wr_en   = accept && (in_byte_present || in_last_byte);
  assign q_valid = (cnt_r != '0);
  assign rd_en   = q_pop && q_valid;
  assign q_item  = mem[rd_ptr_r];

  always_comb begin
    item_in.key_byte = in_key_byte;
    item_in.present  = in_byte_present;
    item_in.last     = in_last_byte;
    item_in.mode     = eff_mode(hash_mode);
  end

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= item_in;
    end
  end

endmodule : shke_front
`default_nettype wire

// ===== sv/shke_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shke_back: hash datapath of the key hash engine
// Updates the running hash one byte per cycle unless the result queue is full, and queues finished hashes.
// ----------------------------------------------------------------------------
module shke_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire shke_pkg::shke_item_t          q_item,
  output logic                               q_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [shke_pkg::HASH_W-1:0]        out_hash_value
);
  import shke_pkg::*;

  logic [HASH_W-1:0]         hash_r, hash_nxt;
  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic                      fresh_r, fresh_nxt;

  logic [HASH_W-1:0]         base_hash;
  logic [HASH_W-1:0]         upd_hash;
  logic [HASH_W-1:0]         sx;
  logic [HASH_W-1:0]         prod;
  logic [POSITION_WIDTH-1:0] base_pos;
  logic [POSITION_WIDTH-1:0] weight;
  logic [POSITION_WIDTH-1:0] upd_pos;
  logic [HASH_W-1:0]         result;
  logic                      step;
  logic                      res_push;

  logic [HASH_W-1:0]         omem [QDEPTH];
  logic [QPTR_W-1:0]         owr_ptr_r, owr_ptr_nxt;
  logic [QPTR_W-1:0]         ord_ptr_r, ord_ptr_nxt;
  logic [QCNT_W-1:0]         ocnt_r, ocnt_nxt;
  logic                      ofull;
  logic                      rd_en;

  // take an item whenever the result queue has room
  assign ofull    = (ocnt_r == QCNT_W'(QDEPTH));
  assign q_pop    = q_valid && !ofull;
  assign step     = q_pop;
  assign res_push = step && q_item.last;

  // key start loads the mode's seed
  always_comb begin
    if (fresh_r) begin
      case (q_item.mode)
        MODE_DJB2: base_hash = DJB2_START;
        MODE_CRC:  base_hash = ALL_ONES;
        default:   base_hash = '0;
      endcase
      base_pos = '0;
    end else begin
      base_hash = hash_r;
      base_pos  = pos_r;
    end
  end

  // per-byte update
  assign sx     = {{(HASH_W-BYTE_W){q_item.key_byte[BYTE_W-1]}}, q_item.key_byte};
  assign weight = base_pos + 1'b1;
  assign prod   = sx * HASH_W'(weight);

  always_comb begin
    upd_hash = base_hash;
    upd_pos  = base_pos;
    if (q_item.present) begin
      upd_pos = weight;
      case (q_item.mode)
        MODE_SUM:  upd_hash = base_hash + sx;
        MODE_POS:  upd_hash = base_hash + prod;
        MODE_DJB2: upd_hash = (base_hash << DJB2_SHIFT) + base_hash + sx;
        MODE_CRC:  upd_hash = crc_byte(base_hash, q_item.key_byte);
        default:   upd_hash = base_hash;
      endcase
    end
  end

  // finished value
  always_comb begin
    case (q_item.mode)
      MODE_LEN: result = HASH_W'(upd_pos);
      MODE_CRC: result = upd_hash ^ ALL_ONES;
      default:  result = upd_hash;
    endcase
  end

  // accumulator state
  always_comb begin
    hash_nxt  = hash_r;
    pos_nxt   = pos_r;
    fresh_nxt = fresh_r;
    if (step) begin
      if (q_item.last) begin
        hash_nxt  = '0;
        pos_nxt   = '0;
        fresh_nxt = 1'b1;
      end else begin
        hash_nxt  = upd_hash;
        pos_nxt   = upd_pos;
        fresh_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r  <= '0;
      pos_r   <= '0;
      fresh_r <= 1'b1;
    end else begin
      hash_r  <= hash_nxt;
      pos_r   <= pos_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  // result queue
  assign empty          = (ocnt_r == '0);
  assign rd_en          = pop && !empty;
  assign out_hash_value = omem[ord_ptr_r];

  always_comb begin
    owr_ptr_nxt = owr_ptr_r;
    ord_ptr_nxt = ord_ptr_r;
    ocnt_nxt    = ocnt_r;
    if (res_push) begin
      owr_ptr_nxt = (owr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : owr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      ord_ptr_nxt = (ord_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : ord_ptr_r + 1'b1;
    end
    if (res_push && !rd_en) begin
      ocnt_nxt = ocnt_r + 1'b1;
    end else if (!res_push && rd_en) begin
      ocnt_nxt = ocnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      omem[owr_ptr_r] <= result;
    end
  end

endmodule : shke_back
`default_nettype wire
